// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge out of reset.
`define SBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants of the stream buffer prefetcher.
// ----------------------------------------------------------------------------
package sbp_pkg;

  localparam int ADDR_WIDTH_DEF   = 8;
  localparam int BUFFER_DEPTH_DEF = 4;
  localparam int NUM_BUFFERS_DEF  = 3;

  localparam int IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_REFILL = 2'd1,
    ACT_ALLOC  = 2'd2
  } action_t;

  typedef struct packed {
    logic             cache_hit;
    action_t          action;
    logic [IDX_W-1:0] buffer_index;
  } sbp_result_t;

endpackage

// ===== hw/rtl/stream_buffer_prefetcher.sv =====
// ----------------------------------------------------------------------------
// stream_buffer_prefetcher
// Access stream in, cache hit flag and stream buffer action out.
// ----------------------------------------------------------------------------
// One word per cycle in and out while out_stall stays low. A word accepted at
// one edge is looked up in the presence bitmap (registered memory read) and
// its result lands in the output register once the pipe advances, which
// raises out_valid. While a result waits under out_stall the whole pipe holds
// and in_stall is high. After reset all 2^ADDR_WIDTH entries (256 by default)
// of the bitmap memory are swept clear through its single write port, one
// entry a cycle, with in_stall high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_buffer_prefetcher
  import sbp_pkg::*;
#(
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_WIDTH-1:0] in_addr,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_cache_hit,
  output logic [1:0]            out_action,
  output logic [IDX_W-1:0]      out_buffer_index
);

  logic                  advance;
  logic                  accept;
  logic                  fire;
  logic                  busy;
  logic                  present;
  logic                  s1_valid_r;
  logic [ADDR_WIDTH-1:0] s1_addr_r;
  logic                  out_valid_r;
  sbp_result_t           res;
  sbp_result_t           out_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = busy || !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid_r && advance;

  sbp_present #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_present (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .wr_en   (fire),
    .wr_addr (s1_addr_r),
    .present (present),
    .busy    (busy)
  );

  sbp_streams #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .NUM_BUFFERS  (NUM_BUFFERS)
  ) u_streams (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .present (present),
    .addr    (s1_addr_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= in_addr;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cache_hit    = out_r.cache_hit;
  assign out_action       = out_r.action;
  assign out_buffer_index = out_r.buffer_index;

  `SBP_ASSERT(a_hit_action, !out_valid_r || (out_cache_hit == (out_action == ACT_NONE)),
              "hit flag and action disagree")
  `SBP_ASSERT(a_no_word_clear, !busy || !s1_valid_r,
              "word in flight during bitmap clear")

endmodule

// ===== hw/rtl/sbp_present.sv =====
// ----------------------------------------------------------------------------
// sbp_present
// Presence bitmap memory with registered read, same-word write forwarding
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbp_present
  import sbp_pkg::*;
#(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [ADDR_WIDTH-1:0] rd_addr,
  input  logic                  wr_en,
  input  logic [ADDR_WIDTH-1:0] wr_addr,
  output logic                  present,
  output logic                  busy
);

  localparam int MEM_DEPTH = 1 << ADDR_WIDTH;

  logic                  mem [MEM_DEPTH];
  logic                  rd_r;
  logic                  clearing_r, clearing_nxt;
  logic [ADDR_WIDTH-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                  fwd;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_WIDTH'(1);
      if (clr_cnt_r == {ADDR_WIDTH{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
  end

  // write in the same edge as the read: take the new value
  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr] | fwd;
    end
  end

  assign present = rd_r;
  assign busy    = clearing_r;

  `SBP_ASSERT_NEXT(a_fwd_seen, rd_en && wr_en && (wr_addr == rd_addr), present,
                   "forwarded write not seen by read")

endmodule

// ===== hw/rtl/sbp_streams.sv =====
// ----------------------------------------------------------------------------
// sbp_streams
// Stream buffer entries: parallel lookup, refill or allocate on a cache miss.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbp_streams
  import sbp_pkg::*;
#(
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic                  present,
  input  logic [ADDR_WIDTH-1:0] addr,
  output sbp_result_t           result
);

  localparam int BW = $clog2(NUM_BUFFERS + 1);
  localparam int CW = (BW < IDX_W) ? IDX_W : BW;

  logic [ADDR_WIDTH-1:0] ent_r [NUM_BUFFERS][BUFFER_DEPTH];
  logic [CW-1:0]         in_use_r, in_use_nxt;
  logic [NUM_BUFFERS-1:0] hold;
  logic [NUM_BUFFERS-1:0] sel;
  logic                  found;
  logic [CW-1:0]         tgt;
  logic [CW-1:0]         chosen;
  logic                  upd;

  always_comb begin
    hold = '0;
    for (int b = 0; b < NUM_BUFFERS; b++) begin
      if (CW'(b) < in_use_r) begin
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
          if (ent_r[b][i] == addr) begin
            hold[b] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    found      = 1'b0;
    tgt        = '0;
    in_use_nxt = in_use_r;
    for (int b = NUM_BUFFERS - 1; b >= 0; b--) begin
      if (hold[b]) begin
        found = 1'b1;
        tgt   = CW'(b);
      end
    end
    if (!found) begin
      if (in_use_r < CW'(NUM_BUFFERS)) begin
        tgt        = in_use_r;
        in_use_nxt = in_use_r + CW'(1);
      end else begin
        tgt = CW'(NUM_BUFFERS - 1);
      end
    end
    for (int b = 0; b < NUM_BUFFERS; b++) begin
      sel[b] = (tgt == CW'(b));
    end
    chosen = tgt + CW'(1);
  end

  always_comb begin
    result.cache_hit    = present;
    result.action       = ACT_NONE;
    result.buffer_index = '0;
    if (!present) begin
      result.action       = found ? ACT_REFILL : ACT_ALLOC;
      result.buffer_index = chosen[IDX_W-1:0];
    end
  end

  assign upd = fire && !present;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (upd) begin
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int b = 0; b < NUM_BUFFERS; b++) begin
        if (sel[b]) begin
          for (int i = 0; i < BUFFER_DEPTH; i++) begin
            ent_r[b][i] <= addr + ADDR_WIDTH'(i + 1);
          end
        end
      end
    end
  end

  `SBP_ASSERT(a_in_use_max, in_use_r <= CW'(NUM_BUFFERS),
              "buffer count above number of buffers")
  `SBP_ASSERT(a_refill_alloc, !(upd && found) || (tgt < in_use_r),
              "refill of an unallocated buffer")

endmodule

// ===== tb/stream_buffer_prefetcher_test.sv =====
// ----------------------------------------------------------------------------
// stream_buffer_prefetcher_test
// Self-checking bench for the stream buffer prefetcher.
// ----------------------------------------------------------------------------
// A short table of directed accesses comes first. It covers both address
// extremes, wrap of the prefetch window, a refill of each buffer, and
// replacement of the last buffer once all are in use. Random accesses follow:
// mostly sequential runs with random bases and strides, plus single random
// addresses. Each accepted access is scored by a local model of the presence
// bitmap and the stream buffers. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module stream_buffer_prefetcher_test;
  import sbp_pkg::*;

  localparam int AW    = ADDR_WIDTH_DEF;
  localparam int DEPTH = BUFFER_DEPTH_DEF;
  localparam int NBUF  = NUM_BUFFERS_DEF;
  localparam int RANDOM_WORDS = 2000;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          fixed;
    sbp_result_t   want;
  } access_row_t;

  localparam int NROWS = 16;
  localparam access_row_t ACCESS_TABLE [NROWS] = '{
    '{8'h00, 1'b1, '{1'b0, ACT_ALLOC, 2'd1}},
    '{8'h00, 1'b1, '{1'b1, ACT_NONE,  2'd0}},
    '{8'hff, 1'b1, '{1'b0, ACT_ALLOC, 2'd2}},
    '{8'h80, 1'b1, '{1'b0, ACT_ALLOC, 2'd3}},
    '{8'h81, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hff, 1'b1, '{1'b1, ACT_NONE,  2'd0}},
    '{8'hc8, 1'b1, '{1'b0, ACT_ALLOC, 2'd3}},
    '{8'h05, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'haa, 1'b0, '0},
    '{8'h7f, 1'b0, '0},
    '{8'hfe, 1'b0, '0},
    '{8'hc9, 1'b0, '0},
    '{8'h00, 1'b1, '{1'b1, ACT_NONE,  2'd0}}
  };

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [AW-1:0]        in_addr   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_cache_hit;
  logic [1:0]           out_action;
  logic [IDX_W-1:0]     out_buffer_index;

  // model state
  logic                 present_bits [2**AW];
  logic [AW-1:0]        stream_buf [NBUF][DEPTH];
  int                   bufs_used;

  sbp_result_t          pending_results [$];
  int                   errors;
  int                   words_sent;
  int                   words_checked;
  int                   n_hits;
  int                   n_refills;
  int                   n_allocs;
  bit                   quiet;

  stream_buffer_prefetcher i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_addr          (in_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cache_hit    (out_cache_hit),
    .out_action       (out_action),
    .out_buffer_index (out_buffer_index)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("timeout: %0d words still pending", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void refill_window(int b, logic [AW-1:0] a);
    for (int i = 0; i < DEPTH; i++) begin
      stream_buf[b][i] = a + AW'(i + 1);
    end
  endfunction

  function automatic sbp_result_t predict_access(logic [AW-1:0] a);
    sbp_result_t r;
    int          b;
    int          hit_buf;
    r = '{1'b0, ACT_NONE, '0};
    hit_buf = -1;
    if (present_bits[a]) begin
      r.cache_hit = 1'b1;
      n_hits++;
      return r;
    end
    present_bits[a] = 1'b1;
    for (b = 0; b < bufs_used && hit_buf < 0; b++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (stream_buf[b][i] == a) hit_buf = b;
      end
    end
    if (hit_buf >= 0) begin
      refill_window(hit_buf, a);
      r.action = ACT_REFILL;
      r.buffer_index = IDX_W'(hit_buf + 1);
      n_refills++;
    end else begin
      if (bufs_used < NBUF) begin
        b = bufs_used;
        bufs_used++;
      end else begin
        b = NBUF - 1;
      end
      refill_window(b, a);
      r.action = ACT_ALLOC;
      r.buffer_index = IDX_W'(b + 1);
      n_allocs++;
    end
    return r;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // Leaves in_valid high after acceptance so a back-to-back word needs no
  // second assignment in the same step.
  task automatic send_word(logic [AW-1:0] a, logic use_fixed, sbp_result_t fixed_want);
    int          gap;
    sbp_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_addr  <= a;
    do @(posedge clk); while (in_stall);
    r = predict_access(a);
    pending_results.push_back(use_fixed ? fixed_want : r);
    words_sent++;
  endtask

  task automatic send_run(logic [AW-1:0] base, int stride, int len);
    for (int j = 0; j < len; j++) begin
      send_word(base + AW'(j * stride), 1'b0, '0);
    end
  endtask

  initial begin : result_side
    int          n;
    sbp_result_t want;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      words_checked++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected word: hit=%0b action=%0d index=%0d",
                             out_cache_hit, out_action, out_buffer_index));
      end else begin
        want = pending_results.pop_front();
        if (out_cache_hit !== want.cache_hit || out_action !== want.action ||
            out_buffer_index !== want.buffer_index) begin
          flag_error($sformatf(
            "word %0d: expected hit=%0b action=%0d index=%0d, got hit=%0b action=%0d index=%0d",
            words_checked, want.cache_hit, want.action, want.buffer_index,
            out_cache_hit, out_action, out_buffer_index));
        end
      end
    end
  end

  initial begin : access_side
    int            target;
    int            tries;
    int            phase_mark;
    bit            pressured;
    logic [AW-1:0] base;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    n_hits = 0;
    n_refills = 0;
    n_allocs = 0;
    bufs_used = 0;
    quiet = 1'b0;
    pressured = 1'b0;
    for (int i = 0; i < 2**AW; i++) present_bits[i] = 1'b0;
    for (int b = 0; b < NBUF; b++) begin
      for (int i = 0; i < DEPTH; i++) stream_buf[b][i] = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NROWS; k++) begin
      send_word(ACCESS_TABLE[k].addr, ACCESS_TABLE[k].fixed, ACCESS_TABLE[k].want);
    end

    target = words_sent + RANDOM_WORDS;
    phase_mark = words_sent;
    while (words_sent < target) begin
      if (words_sent - phase_mark >= 200) begin
        phase_mark = words_sent;
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (!pressured && words_sent >= target - RANDOM_WORDS / 2) begin
        pressured = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        // prefer a base that still misses so the buffers keep working
        base = AW'($urandom_range(0, 2**AW - 1));
        tries = 0;
        while (present_bits[base] && tries < 8) begin
          base = AW'($urandom_range(0, 2**AW - 1));
          tries++;
        end
        send_run(base, ($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : 1,
                 $urandom_range(2, 10));
      end else begin
        send_word(AW'($urandom_range(0, 2**AW - 1)), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);

    $display("covered %0d accesses: %0d cache hits, %0d stream refills, %0d allocations",
             words_sent, n_hits, n_refills, n_allocs);
    $display("checked %0d result words, %0d errors", words_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
